// ===== src/tpog_pkg.sv =====
// Shared types, constants and helpers for the tile path and offset generator.
`timescale 1ns / 1ps

package tpog_pkg;

  // Parameter defaults
  localparam int COORD_BITS_DEF     = 24;
  localparam int MAX_PATH_CHARS_DEF = 31;

  // Configuration register layout
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int COUNT_W    = 9;
  localparam int LEVELS_W   = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACROSS = 2'd0,
    CFG_DOWN   = 2'd1,
    CFG_LEVELS = 2'd2
  } cfg_reg_t;

  localparam logic [COUNT_W-1:0]  ACROSS_RST = 9'd16;
  localparam logic [COUNT_W-1:0]  DOWN_RST   = 9'd16;
  localparam logic [LEVELS_W-1:0] LEVELS_RST = 4'd2;
  localparam logic [COUNT_W-1:0]  MAX_COUNT  = 9'd256;

  // Offset fields
  localparam int IDX_W  = 19;
  localparam int SIZE_W = 20;
  localparam logic [IDX_W-1:0] IDX_BASE = 19'd1024;

  // Path characters
  localparam int DIGIT_W = 6;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_NONE  = 8'h00;

  // Request from the control sequencer to the path emitter
  typedef struct packed {
    logic                blank;
    logic [LEVELS_W-1:0] levels;
    logic [IDX_W-1:0]    idx;
    logic [SIZE_W-1:0]   sz;
  } tpog_req_t;

  // Map a 6-bit digit to its base-64 symbol: A-Z a-z 0-9 + -
  function automatic logic [7:0] b64_char(input logic [DIGIT_W-1:0] v);
    logic [7:0] e;
    logic [7:0] r;
    e = {2'b00, v};
    if (v < 6'd26) begin
      r = 8'h41 + e;
    end else if (v < 6'd52) begin
      r = 8'h61 + e - 8'd26;
    end else if (v < 6'd62) begin
      r = 8'h30 + e - 8'd52;
    end else if (v == 6'd62) begin
      r = 8'h2B;
    end else begin
      r = 8'h2D;
    end
    return r;
  endfunction

endpackage

// ===== src/tpog_div.sv =====
// Shared restoring divider: one quotient bit per cycle, quotient and remainder.
`timescale 1ns / 1ps

module tpog_div #(
  parameter int COORD_BITS = tpog_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [COORD_BITS-1:0]        dividend,
  input  logic [tpog_pkg::COUNT_W-1:0] divisor,
  output logic                         busy,
  output logic                         done,
  output logic [COORD_BITS-1:0]        quotient,
  output logic [tpog_pkg::COUNT_W-1:0] remainder
);

  localparam int CNT_W = $clog2(COORD_BITS + 1);

  logic [CNT_W-1:0]             cnt;
  logic [tpog_pkg::COUNT_W-1:0] dvsr;
  logic [tpog_pkg::COUNT_W:0]   trial;
  logic                         ge;

  // Trial subtract of the divisor from the shifted partial remainder
  always_comb begin
    trial = {remainder, quotient[COORD_BITS-1]};
    ge    = (trial >= {1'b0, dvsr});
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(COORD_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend shifts out of the top while quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvsr      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[COORD_BITS-2:0], ge};
      if (ge) begin
        remainder <= tpog_pkg::COUNT_W'(trial - {1'b0, dvsr});
      end else begin
        remainder <= trial[tpog_pkg::COUNT_W-1:0];
      end
    end
  end

endmodule

// ===== src/tpog_path.sv =====
// Path emitter: walks path sections one char per cycle into output reg unless stalled.
`timescale 1ns / 1ps

module tpog_path #(
  parameter int COORD_BITS     = tpog_pkg::COORD_BITS_DEF,
  parameter int MAX_PATH_CHARS = tpog_pkg::MAX_PATH_CHARS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  tpog_pkg::tpog_req_t         req,
  input  logic [COORD_BITS-1:0]       x,
  input  logic [COORD_BITS-1:0]       y,
  output logic                        busy,
  output logic                        char_valid,
  input  logic                        char_stall,
  output logic [7:0]                  path_char,
  output logic                        last_char,
  output logic                        blank_tile,
  output logic [tpog_pkg::IDX_W-1:0]  index_offset,
  output logic [tpog_pkg::SIZE_W-1:0] size_offset
);

  localparam int ND      = (COORD_BITS + tpog_pkg::DIGIT_W - 1) / tpog_pkg::DIGIT_W;
  localparam int EXT_W   = ND * tpog_pkg::DIGIT_W;
  localparam int MAX_LV  = (1 << tpog_pkg::LEVELS_W) - 1;
  localparam int DI_W    = $clog2(MAX_LV + ND + 1);
  localparam int MAXLEN  = 5 + 2 * ND + 3 * MAX_LV;
  localparam int LEN_TOP = (MAXLEN > MAX_PATH_CHARS) ? MAXLEN : MAX_PATH_CHARS;
  localparam int LEN_W   = $clog2(LEN_TOP + 1);

  typedef enum logic [6:0] {
    P_IDLE  = 7'b0000001,
    P_PREP  = 7'b0000010,
    P_BLANK = 7'b0000100,
    P_ROOT  = 7'b0001000,
    P_HIGH  = 7'b0010000,
    P_LVL   = 7'b0100000,
    P_TAIL  = 7'b1000000
  } p_state_t;

  p_state_t                      state;
  logic [EXT_W-1:0]              xe;
  logic [EXT_W-1:0]              ye;
  logic [tpog_pkg::LEVELS_W-1:0] lv;
  logic                          blank;
  logic [tpog_pkg::IDX_W-1:0]    idx;
  logic [tpog_pkg::SIZE_W-1:0]   sz;
  logic [DI_W-1:0]               di;
  logic [1:0]                    ph;
  logic [LEN_W-1:0]              k;
  logic [LEN_W-1:0]              len;
  logic [LEN_W-1:0]              skip;

  logic [DI_W-1:0]               sig;
  logic [DI_W-1:0]               lv_ext;
  logic [DI_W-1:0]               hp;
  logic [LEN_W-1:0]              len_c;
  logic                          step;
  logic                          emit;
  logic [7:0]                    ch;

  // Pick digit i (counted from the low end) of a coordinate; beyond the top it is zero
  function automatic logic [tpog_pkg::DIGIT_W-1:0] digit_at(input logic [EXT_W-1:0] v,
                                                             input logic [DI_W-1:0] i);
    logic [tpog_pkg::DIGIT_W-1:0] r;
    r = '0;
    for (int g = 0; g < ND; g++) begin
      if (i == DI_W'(g)) r = v[tpog_pkg::DIGIT_W*g +: tpog_pkg::DIGIT_W];
    end
    return r;
  endfunction

  // Count of significant digit pairs and the full path length
  always_comb begin
    sig = '0;
    for (int g = 0; g < ND; g++) begin
      if ((xe[tpog_pkg::DIGIT_W*g +: tpog_pkg::DIGIT_W] |
           ye[tpog_pkg::DIGIT_W*g +: tpog_pkg::DIGIT_W]) != '0) begin
        sig = DI_W'(g + 1);
      end
    end
    lv_ext = DI_W'(lv);
    hp     = (sig > lv_ext) ? sig - lv_ext : DI_W'(1);
    len_c  = LEN_W'(5) + LEN_W'({hp, 1'b0}) + LEN_W'({lv, 1'b0}) + LEN_W'(lv);
  end

  // Character for the current section and phase
  always_comb begin
    unique case (state)
      P_ROOT:  ch = tpog_pkg::CH_SLASH;
      P_HIGH:  ch = ph[0] ? tpog_pkg::b64_char(digit_at(ye, di))
                          : tpog_pkg::b64_char(digit_at(xe, di));
      P_LVL: begin
        case (ph)
          2'd0:    ch = tpog_pkg::CH_SLASH;
          2'd1:    ch = tpog_pkg::b64_char(digit_at(xe, di));
          default: ch = tpog_pkg::b64_char(digit_at(ye, di));
        endcase
      end
      P_TAIL: begin
        case (ph)
          2'd0:    ch = tpog_pkg::CH_DOT;
          2'd1:    ch = tpog_pkg::CH_T;
          2'd2:    ch = tpog_pkg::CH_I;
          default: ch = tpog_pkg::CH_F;
        endcase
      end
      default: ch = tpog_pkg::CH_NONE;
    endcase
  end

  // Advance one character when the output register can take it
  assign step = (state == P_BLANK || state == P_ROOT || state == P_HIGH ||
                 state == P_LVL || state == P_TAIL) && (!char_valid || !char_stall);
  assign emit = step && (k >= skip);
  assign busy = (state != P_IDLE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= P_IDLE;
    end else begin
      unique case (state)
        P_IDLE:  if (start) state <= req.blank ? P_BLANK : P_PREP;
        P_PREP:  state <= P_ROOT;
        P_BLANK: if (step) state <= P_IDLE;
        P_ROOT:  if (step) state <= P_HIGH;
        P_HIGH: begin
          if (step && ph[0] && di == lv_ext) state <= (lv != '0) ? P_LVL : P_TAIL;
        end
        P_LVL: begin
          if (step && ph == 2'd2 && di == '0) state <= P_TAIL;
        end
        P_TAIL:  if (step && ph == 2'd3) state <= P_IDLE;
        default: state <= P_IDLE;
      endcase
    end
  end

  // Section counters and captured request
  always_ff @(posedge clk) begin
    if (state == P_IDLE && start) begin
      xe    <= EXT_W'(x);
      ye    <= EXT_W'(y);
      lv    <= req.levels;
      blank <= req.blank;
      idx   <= req.idx;
      sz    <= req.sz;
      k     <= '0;
      len   <= LEN_W'(1);
      skip  <= '0;
    end else if (state == P_PREP) begin
      len  <= len_c;
      skip <= (len_c > LEN_W'(MAX_PATH_CHARS)) ? len_c - LEN_W'(MAX_PATH_CHARS) : '0;
      di   <= lv_ext + hp - DI_W'(1);
      ph   <= '0;
    end else if (step) begin
      k <= k + 1'b1;
      case (state)
        P_HIGH: begin
          ph <= {1'b0, ~ph[0]};
          if (ph[0]) di <= di - 1'b1;
        end
        P_LVL: begin
          if (ph == 2'd2) begin
            ph <= '0;
            di <= di - 1'b1;
          end else begin
            ph <= ph + 1'b1;
          end
        end
        P_TAIL:  ph <= ph + 1'b1;
        default: ph <= '0;
      endcase
    end
  end

  // Output register: load on emit, drop once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (emit) begin
      char_valid <= 1'b1;
    end else if (!char_stall) begin
      char_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      path_char    <= ch;
      last_char    <= (k == len - 1'b1);
      blank_tile   <= blank;
      index_offset <= idx;
      size_offset  <= sz;
    end
  end

endmodule

// ===== src/tile_path_and_offset_gen.sv =====
// Top level: configuration, divide and offset sequencer, and the path emitter.
//
//  channel   | signals                            | role
//  ----------+------------------------------------+----------------------------------
//  tile      | tile_valid/tile_stall, col, row    | one tile request per transfer
//  char      | char_valid/char_stall, 5 fields    | one path character per transfer
//  cfg       | cfg_we, cfg_index, cfg_data        | register write, no read-back
//
// A blank request (negative coordinate) goes straight to the emitter. Any other request
// runs through the shared bit-serial divider (column, then row), then offset arithmetic,
// handoff to the emitter and its setup, then one path character per cycle while the
// output is not stalled, 5 + 2*pairs + 3*dir_levels characters, counting dropped
// leading ones, and then a return to idle.
// Synchronous reset loads the register defaults and empties the output register.
// A stalled output holds the emitter; tile_stall is high until the emitter has loaded
// the last character into the output register and returned to idle.
`timescale 1ns / 1ps

module tile_path_and_offset_gen #(
  parameter int COORD_BITS     = tpog_pkg::COORD_BITS_DEF,
  parameter int MAX_PATH_CHARS = tpog_pkg::MAX_PATH_CHARS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            tile_valid,
  output logic                            tile_stall,
  input  logic signed [COORD_BITS:0]      tile_col,
  input  logic signed [COORD_BITS:0]      tile_row,
  output logic                            char_valid,
  input  logic                            char_stall,
  output logic [7:0]                      path_char,
  output logic                            last_char,
  output logic                            blank_tile,
  output logic [tpog_pkg::IDX_W-1:0]      index_offset,
  output logic [tpog_pkg::SIZE_W-1:0]     size_offset,
  input  logic                            cfg_we,
  input  logic [tpog_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tpog_pkg::CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DIVC = 7'b0000010,
    S_DIVR = 7'b0000100,
    S_MUL1 = 7'b0001000,
    S_MUL2 = 7'b0010000,
    S_SUM  = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_t;

  state_t                         state;
  logic [tpog_pkg::COUNT_W-1:0]   across;
  logic [tpog_pkg::COUNT_W-1:0]   down;
  logic [tpog_pkg::LEVELS_W-1:0]  levels;
  logic [tpog_pkg::COUNT_W-1:0]   across_c;
  logic [tpog_pkg::COUNT_W-1:0]   down_c;

  logic [COORD_BITS-1:0]          row_mag;
  logic [COORD_BITS-1:0]          xq;
  logic [COORD_BITS-1:0]          yq;
  logic [tpog_pkg::COUNT_W-1:0]   cr;
  logic [tpog_pkg::COUNT_W-1:0]   rr;
  logic [16:0]                    prod;
  logic [15:0]                    n;

  logic                           accept;
  logic                           neg;
  logic                           div_start;
  logic [COORD_BITS-1:0]          div_in;
  logic                           div_busy;
  logic                           div_done;
  logic [COORD_BITS-1:0]          div_q;
  logic [tpog_pkg::COUNT_W-1:0]   div_r;
  logic [tpog_pkg::COUNT_W-1:0]   mul_b;
  logic [17:0]                    mul_full;
  logic [tpog_pkg::IDX_W-1:0]     idx_c;
  logic                           path_start;
  tpog_pkg::tpog_req_t            req;
  logic                           path_busy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      across <= tpog_pkg::ACROSS_RST;
      down   <= tpog_pkg::DOWN_RST;
      levels <= tpog_pkg::LEVELS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tpog_pkg::CFG_ACROSS: across <= cfg_data;
        tpog_pkg::CFG_DOWN:   down   <= cfg_data;
        tpog_pkg::CFG_LEVELS: levels <= cfg_data[tpog_pkg::LEVELS_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the counts into 1..256
  always_comb begin
    across_c = (across == '0) ? tpog_pkg::COUNT_W'(1) :
               (across > tpog_pkg::MAX_COUNT) ? tpog_pkg::MAX_COUNT : across;
    down_c   = (down == '0) ? tpog_pkg::COUNT_W'(1) :
               (down > tpog_pkg::MAX_COUNT) ? tpog_pkg::MAX_COUNT : down;
  end

  assign tile_stall = (state != S_IDLE);
  assign accept     = tile_valid && !tile_stall;
  assign neg        = tile_col[COORD_BITS] || tile_row[COORD_BITS];

  // Shared divider: column first, row on its completion
  assign div_start = (accept && !neg) || (state == S_DIVC && div_done);
  assign div_in    = (state == S_IDLE) ? tile_col[COORD_BITS-1:0] : row_mag;

  tpog_div #(
    .COORD_BITS (COORD_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_in),
    .divisor   ((state == S_IDLE) ? across_c : down_c),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // One multiplier: row remainder times across, then across times down
  assign mul_b    = (state == S_MUL1) ? rr : down_c;
  assign mul_full = across_c * mul_b;
  assign idx_c    = tpog_pkg::IDX_BASE + {1'b0, n, 2'b00};

  // Request to the path emitter
  always_comb begin
    path_start = (accept && neg) || (state == S_SUM);
    req.blank  = (state == S_IDLE);
    req.levels = levels;
    req.idx    = (state == S_IDLE) ? '0 : idx_c;
    req.sz     = (state == S_IDLE) ? '0 : {1'b0, idx_c} + {1'b0, prod, 2'b00};
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:  if (accept) state <= neg ? S_EMIT : S_DIVC;
        S_DIVC:  if (div_done) state <= S_DIVR;
        S_DIVR:  if (div_done) state <= S_MUL1;
        S_MUL1:  state <= S_MUL2;
        S_MUL2:  state <= S_SUM;
        S_SUM:   state <= S_EMIT;
        S_EMIT:  if (!path_busy) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath captures
  always_ff @(posedge clk) begin
    if (accept) row_mag <= tile_row[COORD_BITS-1:0];
    if (state == S_DIVC && div_done) begin
      xq <= div_q;
      cr <= div_r;
    end
    if (state == S_DIVR && div_done) begin
      yq <= div_q;
      rr <= div_r;
    end
    if (state == S_MUL1) prod <= mul_full[16:0];
    if (state == S_MUL2) begin
      n    <= prod[15:0] + {7'd0, cr};
      prod <= mul_full[16:0];
    end
  end

  tpog_path #(
    .COORD_BITS     (COORD_BITS),
    .MAX_PATH_CHARS (MAX_PATH_CHARS)
  ) u_path (
    .clk          (clk),
    .rst          (rst),
    .start        (path_start),
    .req          (req),
    .x            (xq),
    .y            (yq),
    .busy         (path_busy),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .path_char    (path_char),
    .last_char    (last_char),
    .blank_tile   (blank_tile),
    .index_offset (index_offset),
    .size_offset  (size_offset)
  );

  // Checks
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> tile_stall)
    else $error("request accepted but sequencer stayed idle");

  a_no_emit_while_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVC || state == S_DIVR) |-> !path_busy)
    else $error("path emitter active during division");

  a_div_idle_mul: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL1 || state == S_MUL2) |-> !div_busy)
    else $error("divider busy during offset arithmetic");

  a_blank_single: assert property (@(posedge clk) disable iff (rst)
    (char_valid && blank_tile) |-> (last_char && index_offset == '0 && size_offset == '0))
    else $error("blank result not single or offsets nonzero");

endmodule

// ===== bench/tile_path_and_offset_gen_test.sv =====
// Self-checking testbench for the tile path and offset generator.
`timescale 1ns / 1ps

module tile_path_and_offset_gen_test;

  localparam int CB            = tpog_pkg::COORD_BITS_DEF;
  localparam int CW            = CB + 1;
  localparam int CNT_W         = tpog_pkg::COUNT_W;
  localparam int LV_W          = tpog_pkg::LEVELS_W;
  localparam int PATH_MAX      = tpog_pkg::MAX_PATH_CHARS_DEF;
  localparam int HOLD_CYCLES   = 400;
  localparam int IDLE_LIMIT    = 3000;
  localparam int TAIL_CYCLES   = 200;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 41;
  localparam int PRINT_LIMIT   = 40;
  localparam logic [tpog_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [8*64-1:0] DIGITS =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+-";

  // One path character as it leaves the block
  typedef struct packed {
    logic [7:0]                  ch;
    logic                        last;
    logic                        blank;
    logic [tpog_pkg::IDX_W-1:0]  idx;
    logic [tpog_pkg::SIZE_W-1:0] sz;
  } path_res_t;

  typedef enum logic [1:0] {CHK_PRED, CHK_BLANK, CHK_TEXT} chk_t;
  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  // Directed request: settings, coordinates and, where obvious, the expected path
  typedef struct packed {
    logic signed [CB:0]          col;
    logic signed [CB:0]          row;
    logic [CNT_W-1:0]            across;
    logic [CNT_W-1:0]            down;
    logic [LV_W-1:0]             levels;
    chk_t                        chk;
    logic [8*32-1:0]             text;
    logic [tpog_pkg::IDX_W-1:0]  idx;
    logic [tpog_pkg::SIZE_W-1:0] sz;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [0:18] = '{
    // reset settings
    '{25'sd0, 25'sd0, 9'd16, 9'd16, 4'd2, CHK_TEXT, "/AA/AA/AA.tif", 19'd1024, 20'd2048},
    '{25'h1FFFFFF, 25'sd0, 9'd16, 9'd16, 4'd2, CHK_BLANK, 256'd0, 19'd0, 20'd0},
    '{25'sd0, 25'h1FFFFFF, 9'd16, 9'd16, 4'd2, CHK_BLANK, 256'd0, 19'd0, 20'd0},
    '{25'h1000000, 25'h1000000, 9'd16, 9'd16, 4'd2, CHK_BLANK, 256'd0, 19'd0, 20'd0},
    '{25'sd16777215, 25'sd16777215, 9'd16, 9'd16, 4'd2, CHK_PRED, 256'd0, 19'd0, 20'd0},
    '{25'sd16777215, 25'sd0, 9'd16, 9'd16, 4'd2, CHK_PRED, 256'd0, 19'd0, 20'd0},
    '{25'sd15, 25'sd15, 9'd16, 9'd16, 4'd2, CHK_TEXT, "/AA/AA/AA.tif", 19'd2044, 20'd3068},
    '{25'sd16, 25'sd32, 9'd16, 9'd16, 4'd2, CHK_PRED, 256'd0, 19'd0, 20'd0},
    '{25'h1000000, 25'sd16777215, 9'd16, 9'd16, 4'd2, CHK_BLANK, 256'd0, 19'd0, 20'd0},
    // zero counts act as one, no fixed levels
    '{25'sd0, 25'sd0, 9'd0, 9'd0, 4'd0, CHK_TEXT, "/AA.tif", 19'd1024, 20'd1028},
    '{25'sd16777215, 25'sd16777215, 9'd0, 9'd0, 4'd0, CHK_PRED, 256'd0, 19'd0, 20'd0},
    // oversized counts act as 256; path exactly at the length limit
    '{25'sd16777215, 25'sd16777215, 9'd511, 9'd300, 4'd8, CHK_PRED, 256'd0, 19'd0, 20'd0},
    '{25'sd255, 25'sd255, 9'd511, 9'd300, 4'd8, CHK_TEXT,
      "/AA/AA/AA/AA/AA/AA/AA/AA/AA.tif", 19'd263164, 20'd525308},
    // deep levels: path cut to its tail
    '{25'sd0, 25'sd0, 9'd256, 9'd256, 4'd9, CHK_PRED, 256'd0, 19'd0, 20'd0},
    '{25'sd16777215, 25'sd0, 9'd256, 9'd256, 4'd9, CHK_PRED, 256'd0, 19'd0, 20'd0},
    '{25'sd16777215, 25'sd16777215, 9'd1, 9'd1, 4'd15, CHK_PRED, 256'd0, 19'd0, 20'd0},
    '{25'h1FFFFFF, 25'h1FFFFFF, 9'd1, 9'd1, 4'd15, CHK_BLANK, 256'd0, 19'd0, 20'd0},
    // lopsided counts
    '{25'sd12345, 25'sd16777215, 9'd1, 9'd256, 4'd1, CHK_PRED, 256'd0, 19'd0, 20'd0},
    '{25'sd16777215, 25'sd1, 9'd1, 9'd256, 4'd1, CHK_PRED, 256'd0, 19'd0, 20'd0}
  };

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            tile_valid;
  logic                            tile_stall;
  logic signed [CB:0]              tile_col;
  logic signed [CB:0]              tile_row;
  logic                            char_valid;
  logic                            char_stall;
  logic [7:0]                      path_char;
  logic                            last_char;
  logic                            blank_tile;
  logic [tpog_pkg::IDX_W-1:0]      index_offset;
  logic [tpog_pkg::SIZE_W-1:0]     size_offset;
  logic                            cfg_we;
  logic [tpog_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [tpog_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                            hold_req;

  // Register mirror
  logic [CNT_W-1:0] cfg_across;
  logic [CNT_W-1:0] cfg_down;
  logic [LV_W-1:0]  cfg_levels;

  path_res_t expected_chars[$];

  int errors, items_sent, blanks_sent, chars_seen, long_paths, holds_done;
  int settings_used, burst_left, idle_cycles;
  bit steady;

  tile_path_and_offset_gen dut (.*);

  always #4 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (errors < PRINT_LIMIT)
      $display("char %0d: %s got %0h, expected %0h", chars_seen, what, got, want);
    errors++;
  endtask

  function automatic int unsigned eff_count(input logic [CNT_W-1:0] v);
    if (v == 0) return 1;
    if (v > tpog_pkg::MAX_COUNT) return 32'(tpog_pkg::MAX_COUNT);
    return 32'(v);
  endfunction

  function automatic logic [7:0] digit_sym(input int unsigned v);
    return DIGITS[8*(63-(v & 63)) +: 8];
  endfunction

  // Work out the characters that one tile request should produce
  function automatic void predict_path(input logic signed [CB:0] c,
                                       input logic signed [CB:0] r);
    int unsigned across, down, x, y, n, idx, sz;
    byte unsigned path[$];
    path_res_t e;
    if (c[CB] || r[CB]) begin
      expected_chars.push_back('{tpog_pkg::CH_NONE, 1'b1, 1'b1, '0, '0});
      return;
    end
    across = eff_count(cfg_across);
    down = eff_count(cfg_down);
    x = c[CB-1:0] / across;
    y = r[CB-1:0] / down;
    n = (r[CB-1:0] % down) * across + c[CB-1:0] % across;
    idx = tpog_pkg::IDX_BASE + 4 * n;
    sz = idx + 4 * across * down;
    // assemble from the tail forward
    path.push_front(tpog_pkg::CH_F);
    path.push_front(tpog_pkg::CH_I);
    path.push_front(tpog_pkg::CH_T);
    path.push_front(tpog_pkg::CH_DOT);
    for (int d = 0; d < cfg_levels; d++) begin
      path.push_front(digit_sym(y));
      path.push_front(digit_sym(x));
      path.push_front(tpog_pkg::CH_SLASH);
      x = x >> 6;
      y = y >> 6;
    end
    do begin
      path.push_front(digit_sym(y));
      path.push_front(digit_sym(x));
      x = x >> 6;
      y = y >> 6;
    end while (x != 0 || y != 0);
    path.push_front(tpog_pkg::CH_SLASH);
    // keep only the tail of an overlong path
    if (path.size() > PATH_MAX) begin
      long_paths++;
      while (path.size() > PATH_MAX) void'(path.pop_front());
    end
    foreach (path[k]) begin
      e = '{path[k], k == path.size() - 1, 1'b0, idx[tpog_pkg::IDX_W-1:0],
            sz[tpog_pkg::SIZE_W-1:0]};
      expected_chars.push_back(e);
    end
  endfunction

  // Queue a path typed in by hand, right-aligned in the text field
  function automatic void push_text(input logic [8*32-1:0] text,
                                    input logic [tpog_pkg::IDX_W-1:0] idx,
                                    input logic [tpog_pkg::SIZE_W-1:0] sz);
    int first;
    first = 0;
    while (text[8*(31-first) +: 8] == 8'h00) first++;
    for (int k = first; k < 32; k++)
      expected_chars.push_back('{text[8*(31-k) +: 8], k == 31, 1'b0, idx, sz});
  endfunction

  function automatic logic signed [CB:0] rand_coord();
    logic signed [CB:0] v;
    logic [31:0] w;
    w = $urandom();
    case ($urandom_range(0, 9))
      0: v = {1'b1, w[CB-1:0]};
      1, 2: v = CW'($urandom_range(0, 600));
      3: v = CW'((1 << CB) - 1 - $urandom_range(0, 3));
      default: v = {1'b0, w[CB-1:0]};
    endcase
    return v;
  endfunction

  function automatic logic [CNT_W-1:0] pick_count();
    logic [CNT_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = 9'd1;
      2: v = tpog_pkg::MAX_COUNT;
      3: v = CNT_W'($urandom_range(257, 511));
      default: v = CNT_W'($urandom_range(2, 255));
    endcase
    return v;
  endfunction

  // Write all three registers on consecutive edges
  task automatic set_config(input logic [CNT_W-1:0] a, input logic [CNT_W-1:0] d,
                            input logic [LV_W-1:0] l);
    cfg_we <= 1'b1;
    cfg_index <= tpog_pkg::CFG_ACROSS;
    cfg_data <= a;
    @(posedge clk);
    cfg_index <= tpog_pkg::CFG_DOWN;
    cfg_data <= d;
    @(posedge clk);
    cfg_index <= tpog_pkg::CFG_LEVELS;
    cfg_data <= {{(tpog_pkg::CFG_DATA_W-LV_W){1'b0}}, l};
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_across = a;
    cfg_down = d;
    cfg_levels = l;
    settings_used++;
  endtask

  // Offer one request and hold it until the transfer
  task automatic send_tile(input logic signed [CB:0] c, input logic signed [CB:0] r);
    tile_valid <= 1'b1;
    tile_col <= c;
    tile_row <= r;
    @(posedge clk);
    while (tile_stall) @(posedge clk);
    items_sent++;
    if (c[CB] || r[CB]) blanks_sent++;
  endtask

  // End a burst now and then with a gap
  task automatic sender_gap();
    if (steady) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      tile_valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
  endtask

  task automatic drain_results();
    while (expected_chars.size() != 0) @(posedge clk);
  endtask

  // Receiver: changing stall pattern, plus one long hold on request
  initial begin
    int tick, mode_left;
    rx_mode_t mode;
    tick = 0;
    mode_left = 0;
    mode = RX_OPEN;
    char_stall <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_req && holds_done == 0) begin
        char_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (mode)
          RX_OPEN: char_stall <= 1'b0;
          RX_LIGHT: char_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY: char_stall <= ($urandom_range(0, 3) != 0);
          default: char_stall <= tick[2];
        endcase
      end
    end
  end

  // Compare each character transfer with the oldest expectation
  always @(posedge clk) begin : check_chars
    path_res_t want;
    if (!rst && char_valid && !char_stall) begin
      chars_seen++;
      if (expected_chars.size() == 0) begin
        report_mismatch("unexpected transfer, path_char", 32'(path_char), 0);
      end else begin
        want = expected_chars.pop_front();
        if (path_char !== want.ch)
          report_mismatch("path_char", 32'(path_char), 32'(want.ch));
        if (last_char !== want.last)
          report_mismatch("last_char", 32'(last_char), 32'(want.last));
        if (blank_tile !== want.blank)
          report_mismatch("blank_tile", 32'(blank_tile), 32'(want.blank));
        if (index_offset !== want.idx)
          report_mismatch("index_offset", 32'(index_offset), 32'(want.idx));
        if (size_offset !== want.sz)
          report_mismatch("size_offset", 32'(size_offset), 32'(want.sz));
      end
    end
  end

  // Watchdog: too long without any transfer
  always @(posedge clk) begin
    if ((tile_valid && !tile_stall) || (char_valid && !char_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic signed [CB:0] c, r;
    rst <= 1'b1;
    tile_valid <= 1'b0;
    tile_col <= '0;
    tile_row <= '0;
    cfg_we <= 1'b0;
    cfg_index <= tpog_pkg::CFG_ACROSS;
    cfg_data <= '0;
    hold_req <= 1'b0;
    cfg_across = tpog_pkg::ACROSS_RST;
    cfg_down = tpog_pkg::DOWN_RST;
    cfg_levels = tpog_pkg::LEVELS_RST;
    burst_left = 0;
    steady = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // a write to the spare index must leave every register alone
    cfg_we <= 1'b1;
    cfg_index <= CFG_UNUSED;
    cfg_data <= '1;
    @(posedge clk);
    cfg_we <= 1'b0;

    // directed requests
    for (int i = 0; i < $size(DIR_TAB); i++) begin
      if (DIR_TAB[i].across != cfg_across || DIR_TAB[i].down != cfg_down ||
          DIR_TAB[i].levels != cfg_levels) begin
        tile_valid <= 1'b0;
        drain_results();
        set_config(DIR_TAB[i].across, DIR_TAB[i].down, DIR_TAB[i].levels);
      end
      send_tile(DIR_TAB[i].col, DIR_TAB[i].row);
      case (DIR_TAB[i].chk)
        CHK_BLANK: expected_chars.push_back('{tpog_pkg::CH_NONE, 1'b1, 1'b1, '0, '0});
        CHK_TEXT: push_text(DIR_TAB[i].text, DIR_TAB[i].idx, DIR_TAB[i].sz);
        default: predict_path(DIR_TAB[i].col, DIR_TAB[i].row);
      endcase
      sender_gap();
    end
    tile_valid <= 1'b0;
    drain_results();

    // random requests, one register setting per phase
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: set_config(tpog_pkg::ACROSS_RST, tpog_pkg::DOWN_RST, tpog_pkg::LEVELS_RST);
        1: set_config(tpog_pkg::MAX_COUNT, tpog_pkg::MAX_COUNT, 4'd8);
        2: set_config(9'd1, 9'd1, 4'd15);
        default: set_config(pick_count(), pick_count(),
                            LV_W'(($urandom_range(0, 3) == 0) ? $urandom_range(9, 15)
                                                              : $urandom_range(0, 8)));
      endcase
      steady = (p % 3 == 1);
      // back-pressure: the receiver stops while requests keep coming
      hold_req <= (p == 1);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        c = rand_coord();
        r = rand_coord();
        send_tile(c, r);
        predict_path(c, r);
        sender_gap();
      end
      tile_valid <= 1'b0;
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d tile requests (%0d blank) over %0d register settings, %0d chars.",
             items_sent, blanks_sent, settings_used, chars_seen);
    $display("%0d paths were cut to the length limit; receiver long holds: %0d.",
             long_paths, holds_done);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
